// ===== src/bsp_pkg.sv =====
`default_nettype none
package bsp_pkg;

    // memory kinds of a page entry
    localparam logic [2:0] KIND_ROM  = 3'd0;
    localparam logic [2:0] KIND_RAM  = 3'd1;
    localparam logic [2:0] KIND_XRAM = 3'd2;
    localparam logic [2:0] KIND_WRAM = 3'd3;
    localparam logic [2:0] KIND_VROM = 3'd4;
    localparam logic [2:0] KIND_CRAM = 3'd5;
    localparam logic [2:0] KIND_VRAM = 3'd6;

    // command codes
    localparam logic [3:0] OP_ROM8    = 4'd0;
    localparam logic [3:0] OP_ROM16   = 4'd1;
    localparam logic [3:0] OP_ROM32   = 4'd2;
    localparam logic [3:0] OP_WRAM    = 4'd3;
    localparam logic [3:0] OP_VROM1   = 4'd4;
    localparam logic [3:0] OP_VROM2   = 4'd5;
    localparam logic [3:0] OP_VROM4   = 4'd6;
    localparam logic [3:0] OP_VROM8   = 4'd7;
    localparam logic [3:0] OP_CRAM1   = 4'd8;
    localparam logic [3:0] OP_CRAM2   = 4'd9;
    localparam logic [3:0] OP_CRAM4   = 4'd10;
    localparam logic [3:0] OP_CRAM8   = 4'd11;
    localparam logic [3:0] OP_VRAM    = 4'd12;
    localparam logic [3:0] OP_MIRROR  = 4'd13;
    localparam logic [3:0] OP_NT      = 4'd14;

    // mirroring modes
    localparam logic [2:0] MIR_VERT   = 3'd0;
    localparam logic [2:0] MIR_HORZ   = 3'd1;
    localparam logic [2:0] MIR_HIGH   = 3'd2;
    localparam logic [2:0] MIR_LOW    = 3'd3;
    localparam logic [2:0] MIR_FOUR   = 3'd4;

    localparam int CPU_PAGES = 8;
    localparam int PPU_PAGES = 16;

    // one queued command, already classified
    typedef struct packed {
        logic [2:0]  kind;
        logic        tsel;
        logic        mirror;
        logic [3:0]  first;
        logic [1:0]  clog;
        logic [2:0]  last_idx;
        logic [11:0] bank;
        logic [7:0]  nt;
    } bsp_cmd_t;

    // command queue head as seen by the back end
    typedef struct packed {
        logic     empty;
        bsp_cmd_t cmd;
    } bsp_qhead_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_START,
        B_DIV,
        B_EMIT
    } bsp_bstate_t;

    // nametable banks {nt3, nt2, nt1, nt0} of a mirroring mode
    function automatic logic [7:0] mirror_nt(input logic [2:0] mode);
        logic [7:0] r;
        r = 8'h00;
        unique case (mode)
            MIR_VERT: r = 8'b01_00_01_00;
            MIR_HORZ: r = 8'b01_01_00_00;
            MIR_HIGH: r = 8'b01_01_01_01;
            MIR_LOW:  r = 8'b00_00_00_00;
            MIR_FOUR: r = 8'b11_10_01_00;
            default:  r = 8'h00;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== src/bsp_front.sv =====
`default_nettype none
module bsp_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [3:0]         operation,
    input  wire logic [3:0]         page,
    input  wire logic [11:0]        bank,
    input  wire logic [2:0]         mirror_mode,
    input  wire logic [1:0]         nt_bank0,
    input  wire logic [1:0]         nt_bank1,
    input  wire logic [1:0]         nt_bank2,
    input  wire logic [1:0]         nt_bank3,
    input  wire logic               vrom_none,
    output bsp_pkg::bsp_qhead_t     head,
    input  wire logic               head_pop
);

    bsp_pkg::bsp_cmd_t q_reg [2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        cnt_reg, cnt_next;
    bsp_pkg::bsp_cmd_t cmd;
    logic              keep;
    logic              enq;
    logic              deq;

    // classify the incoming command
    always_comb
    begin
        cmd          = '0;
        keep         = 1'b1;
        cmd.first    = page;
        cmd.bank     = bank;
        cmd.nt       = {nt_bank3, nt_bank2, nt_bank1, nt_bank0};
        case (operation)
            bsp_pkg::OP_ROM8, bsp_pkg::OP_ROM16, bsp_pkg::OP_ROM32:
            begin
                cmd.kind     = bsp_pkg::KIND_ROM;
                cmd.clog     = operation[1:0];
                cmd.last_idx = 3'((1 << operation[1:0]) - 1);
                if (operation == bsp_pkg::OP_ROM32)
                    cmd.first = 4'd4;
            end
            bsp_pkg::OP_WRAM:
            begin
                cmd.kind = bsp_pkg::KIND_WRAM;
            end
            bsp_pkg::OP_VROM1, bsp_pkg::OP_VROM2, bsp_pkg::OP_VROM4, bsp_pkg::OP_VROM8,
            bsp_pkg::OP_CRAM1, bsp_pkg::OP_CRAM2, bsp_pkg::OP_CRAM4, bsp_pkg::OP_CRAM8:
            begin
                cmd.tsel     = 1'b1;
                cmd.kind     = (!operation[3] && !vrom_none) ? bsp_pkg::KIND_VROM
                                                             : bsp_pkg::KIND_CRAM;
                cmd.clog     = operation[1:0];
                cmd.last_idx = 3'((1 << operation[1:0]) - 1);
                if (operation[1:0] == 2'd3)
                    cmd.first = 4'd0;
            end
            bsp_pkg::OP_VRAM:
            begin
                cmd.tsel = 1'b1;
                cmd.kind = bsp_pkg::KIND_VRAM;
            end
            bsp_pkg::OP_MIRROR, bsp_pkg::OP_NT:
            begin
                cmd.tsel     = 1'b1;
                cmd.kind     = bsp_pkg::KIND_VRAM;
                cmd.mirror   = 1'b1;
                cmd.first    = 4'd8;
                cmd.last_idx = 3'd7;
                if (operation == bsp_pkg::OP_MIRROR)
                begin
                    cmd.nt = bsp_pkg::mirror_nt(mirror_mode);
                    keep   = (mirror_mode <= bsp_pkg::MIR_FOUR);
                end
            end
            default: keep = 1'b0;
        endcase
    end

    assign full        = (cnt_reg == 2'd2);
    assign enq         = push && !full && keep;
    assign deq         = head_pop && (cnt_reg != 2'd0);
    assign head.empty  = (cnt_reg == 2'd0);
    assign head.cmd    = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = enq ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = deq ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = 2'(cnt_reg + {1'b0, enq} - {1'b0, deq});
    end

    // advance queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // store the classified command
    always_ff @(posedge clk)
    begin
        if (enq)
            q_reg[wr_ptr_reg] <= cmd;
    end

endmodule
`default_nettype wire

// ===== src/bsp_div.sv =====
`default_nettype none
module bsp_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [14:0] dividend,
    input  wire logic [11:0] divisor,
    output logic             done,
    output logic [11:0]      rem
);

    logic [11:0] rem_reg, rem_next;
    logic [14:0] dvd_reg, dvd_next;
    logic [11:0] dsr_reg;
    logic [3:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [12:0] trial;

    // one restoring step per cycle, MSB first
    always_comb
    begin
        trial     = {rem_reg, dvd_reg[14]};
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = 12'd0;
            dvd_next  = dividend;
            cnt_next  = 4'd14;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
                rem_next = 12'(trial - {1'b0, dsr_reg});
            else
                rem_next = trial[11:0];
            dvd_next = {dvd_reg[13:0], 1'b0};
            cnt_next = 4'(cnt_reg - 4'd1);
            if (cnt_reg == 4'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 4'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        if (start)
            dsr_reg <= divisor;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule
`default_nettype wire

// ===== src/bsp_back.sv =====
`default_nettype none
module bsp_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire bsp_pkg::bsp_qhead_t head,
    output logic                    head_pop,
    input  wire logic [9:0]         rom_banks,
    input  wire logic [11:0]        vrom_banks,
    output logic                    out_valid,
    input  wire logic               out_pop,
    output logic                    table_select,
    output logic [3:0]              slot,
    output logic [2:0]              memory_kind,
    output logic [21:0]             byte_offset,
    output logic                    cpu_flush,
    output logic                    last
);

    bsp_pkg::bsp_bstate_t state_reg, state_next;
    bsp_pkg::bsp_cmd_t    cmd_reg;
    logic [2:0]           idx_reg, idx_next;
    logic                 load_cmd;
    logic [2:0]           cpu_kind_reg [bsp_pkg::CPU_PAGES];
    logic [21:0]          cpu_off_reg  [bsp_pkg::CPU_PAGES];
    logic                 ov_reg, ov_next;
    logic                 emit;
    logic [14:0]          value;
    logic [1:0]           nt_sel;
    logic [3:0]           eslot;
    logic [21:0]          offset;
    logic                 flush;
    logic [11:0]          rom_mod;
    logic [11:0]          vrom_n;
    logic [11:0]          divisor;
    logic                 need_div;
    logic                 div_start;
    logic                 div_done;
    logic [11:0]          rem;

    bsp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (value),
        .divisor  (divisor),
        .done     (div_done),
        .rem      (rem)
    );

    // entry value, slot and moduli
    always_comb
    begin
        nt_sel  = idx_reg[1:0];
        value   = 15'(({3'b000, cmd_reg.bank} << cmd_reg.clog) | {12'd0, idx_reg});
        if (cmd_reg.mirror)
            value = {13'd0, cmd_reg.nt[{nt_sel, 1'b0} +: 2]};
        eslot   = 4'(cmd_reg.first + {1'b0, idx_reg});
        if (!cmd_reg.tsel)
            eslot = {1'b0, eslot[2:0]};
        rom_mod = (rom_banks == 10'd0) ? 12'd1 :
                  (rom_banks > 10'd512) ? 12'd512 : {2'b00, rom_banks};
        vrom_n  = (vrom_banks > 12'd2048) ? 12'd2048 : vrom_banks;
        divisor  = (cmd_reg.kind == bsp_pkg::KIND_ROM) ? rom_mod : vrom_n;
        need_div = (cmd_reg.kind == bsp_pkg::KIND_ROM) ||
                   (cmd_reg.kind == bsp_pkg::KIND_VROM);
    end

    // byte offset of the entry and its flush flag
    always_comb
    begin
        case (cmd_reg.kind)
            bsp_pkg::KIND_ROM:  offset = {rem[8:0], 13'd0};
            bsp_pkg::KIND_WRAM: offset = {2'b00, value[6:0], 13'd0};
            bsp_pkg::KIND_VROM: offset = {1'b0, rem[10:0], 10'd0};
            bsp_pkg::KIND_CRAM: offset = {7'd0, value[4:0], 10'd0};
            default:            offset = {10'd0, value[1:0], 10'd0};
        endcase
        flush = (cmd_reg.kind == bsp_pkg::KIND_ROM) &&
                ((cpu_kind_reg[eslot[2:0]] != bsp_pkg::KIND_ROM) ||
                 (cpu_off_reg[eslot[2:0]] != offset));
    end

    // sequencer over the entries of one command
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        load_cmd   = 1'b0;
        head_pop   = 1'b0;
        div_start  = 1'b0;
        emit       = 1'b0;
        ov_next    = ov_reg && !out_pop;
        unique case (state_reg)
            bsp_pkg::B_IDLE:
            begin
                if (!head.empty)
                begin
                    load_cmd   = 1'b1;
                    head_pop   = 1'b1;
                    idx_next   = 3'd0;
                    state_next = bsp_pkg::B_START;
                end
            end
            bsp_pkg::B_START:
            begin
                if (need_div)
                begin
                    div_start  = 1'b1;
                    state_next = bsp_pkg::B_DIV;
                end
                else
                    state_next = bsp_pkg::B_EMIT;
            end
            bsp_pkg::B_DIV:
            begin
                if (div_done)
                    state_next = bsp_pkg::B_EMIT;
            end
            bsp_pkg::B_EMIT:
            begin
                if (!ov_reg)
                begin
                    emit    = 1'b1;
                    ov_next = 1'b1;
                    if (idx_reg == cmd_reg.last_idx)
                        state_next = bsp_pkg::B_IDLE;
                    else
                    begin
                        idx_next   = 3'(idx_reg + 3'd1);
                        state_next = bsp_pkg::B_START;
                    end
                end
            end
            default: state_next = bsp_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bsp_pkg::B_IDLE;
            idx_reg   <= 3'd0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            ov_reg    <= ov_next;
        end
    end

    // hold the command and the result payload
    always_ff @(posedge clk)
    begin
        if (load_cmd)
            cmd_reg <= head.cmd;
        if (emit)
        begin
            table_select <= cmd_reg.tsel;
            slot         <= eslot;
            memory_kind  <= cmd_reg.kind;
            byte_offset  <= offset;
            cpu_flush    <= flush;
            last         <= (idx_reg == cmd_reg.last_idx);
        end
    end

    // CPU page table, compared on ROM writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpu_kind_reg[0] <= bsp_pkg::KIND_RAM;
            cpu_kind_reg[1] <= bsp_pkg::KIND_XRAM;
            cpu_kind_reg[2] <= bsp_pkg::KIND_XRAM;
            cpu_kind_reg[3] <= bsp_pkg::KIND_WRAM;
            cpu_kind_reg[4] <= bsp_pkg::KIND_ROM;
            cpu_kind_reg[5] <= bsp_pkg::KIND_ROM;
            cpu_kind_reg[6] <= bsp_pkg::KIND_ROM;
            cpu_kind_reg[7] <= bsp_pkg::KIND_ROM;
            cpu_off_reg[0]  <= 22'd0;
            cpu_off_reg[1]  <= 22'd0;
            cpu_off_reg[2]  <= 22'd0;
            cpu_off_reg[3]  <= 22'd0;
            cpu_off_reg[4]  <= 22'd0;
            cpu_off_reg[5]  <= 22'h002000;
            cpu_off_reg[6]  <= 22'd0;
            cpu_off_reg[7]  <= 22'h002000;
        end
        else if (emit && !cmd_reg.tsel)
        begin
            cpu_kind_reg[eslot[2:0]] <= cmd_reg.kind;
            cpu_off_reg[eslot[2:0]]  <= offset;
        end
    end

    assign out_valid = ov_reg;

endmodule
`default_nettype wire

// ===== src/bank_switch_page_table_unit.sv =====
`default_nettype none
// Channel   Handshake           Payload
// command   push / full         operation page bank mirror_mode nt_bank0..3
// result    empty / pop         table_select slot memory_kind byte_offset cpu_flush last
// config    APB psel/penable    paddr pwdata prdata pready (always ready)
//
// A command is queued in the front end; the back end loads it, then for each
// entry passes through start and emit, waiting between them on the bit-serial
// remainder unit for ROM and VROM entries.
// Two commands queue ahead of the back end; full rises when both are taken.
// A result waits in the output register until popped; the back end stalls.
// Reset is asynchronous and loads the power-on page table at once.
module bank_switch_page_table_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [3:0]  operation,
    input  wire logic [3:0]  page,
    input  wire logic [11:0] bank,
    input  wire logic [2:0]  mirror_mode,
    input  wire logic [1:0]  nt_bank0,
    input  wire logic [1:0]  nt_bank1,
    input  wire logic [1:0]  nt_bank2,
    input  wire logic [1:0]  nt_bank3,
    output logic             empty,
    input  wire logic        pop,
    output logic             table_select,
    output logic [3:0]       slot,
    output logic [2:0]       memory_kind,
    output logic [21:0]      byte_offset,
    output logic             cpu_flush,
    output logic             last,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [9:0]          rom_reg;
    logic [11:0]         vrom_reg;
    logic                cfg_wr;
    bsp_pkg::bsp_qhead_t head;
    logic                head_pop;
    logic                out_valid;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_reg  <= 10'd2;
            vrom_reg <= 12'd0;
        end
        else if (cfg_wr)
        begin
            if (paddr[2])
                vrom_reg <= pwdata[11:0];
            else
                rom_reg  <= pwdata[9:0];
        end
    end

    assign prdata = paddr[2] ? {20'd0, vrom_reg} : {22'd0, rom_reg};

    bsp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .operation   (operation),
        .page        (page),
        .bank        (bank),
        .mirror_mode (mirror_mode),
        .nt_bank0    (nt_bank0),
        .nt_bank1    (nt_bank1),
        .nt_bank2    (nt_bank2),
        .nt_bank3    (nt_bank3),
        .vrom_none   (vrom_reg == 12'd0),
        .head        (head),
        .head_pop    (head_pop)
    );

    bsp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .head_pop     (head_pop),
        .rom_banks    (rom_reg),
        .vrom_banks   (vrom_reg),
        .out_valid    (out_valid),
        .out_pop      (pop),
        .table_select (table_select),
        .slot         (slot),
        .memory_kind  (memory_kind),
        .byte_offset  (byte_offset),
        .cpu_flush    (cpu_flush),
        .last         (last)
    );

    assign empty = !out_valid;

endmodule
`default_nettype wire

// ===== src/bsp_checker.sv =====
`default_nettype none
module bsp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic        table_select,
    input wire logic [3:0]  slot,
    input wire logic [2:0]  memory_kind,
    input wire logic [21:0] byte_offset,
    input wire logic        cpu_flush
);

    // a waiting result holds until transferred
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(byte_offset) && $stable(slot)))
        else $error("result changed before transfer");

    // CPU results name slots 0-7 only
    a_cpu_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !table_select) |-> !slot[3])
        else $error("CPU slot out of range");

    // flush only on CPU ROM entries
    a_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && cpu_flush) |-> (!table_select && memory_kind == bsp_pkg::KIND_ROM))
        else $error("flush on a non-ROM entry");

    // PPU entries are VROM, CRAM or VRAM
    a_ppu_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && table_select) |-> (memory_kind == bsp_pkg::KIND_VROM ||
            memory_kind == bsp_pkg::KIND_CRAM || memory_kind == bsp_pkg::KIND_VRAM))
        else $error("bad PPU memory kind");

endmodule

bind bank_switch_page_table_unit bsp_checker u_bsp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .empty        (empty),
    .pop          (pop),
    .table_select (table_select),
    .slot         (slot),
    .memory_kind  (memory_kind),
    .byte_offset  (byte_offset),
    .cpu_flush    (cpu_flush)
);
`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
module tb;
    import bsp_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE       = 400;
    localparam logic [2:0] REG_ROM_BANKS  = 3'd0;
    localparam logic [2:0] REG_VROM_BANKS = 3'd4;
    localparam logic [3:0] OP_UNUSED = 4'd15;

    typedef struct packed {
        logic        tsel;
        logic [3:0]  slot;
        logic [2:0]  kind;
        logic [21:0] offset;
        logic        flush;
        logic        last;
    } page_update_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [3:0]  operation = '0;
    logic [3:0]  page = '0;
    logic [11:0] bank = '0;
    logic [2:0]  mirror_mode = '0;
    logic [1:0]  nt_bank0 = '0;
    logic [1:0]  nt_bank1 = '0;
    logic [1:0]  nt_bank2 = '0;
    logic [1:0]  nt_bank3 = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic        table_select;
    logic [3:0]  slot;
    logic [2:0]  memory_kind;
    logic [21:0] byte_offset;
    logic        cpu_flush;
    logic        last;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    bank_switch_page_table_unit i_dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .operation(operation), .page(page), .bank(bank), .mirror_mode(mirror_mode),
        .nt_bank0(nt_bank0), .nt_bank1(nt_bank1), .nt_bank2(nt_bank2),
        .nt_bank3(nt_bank3), .empty(empty), .pop(pop), .table_select(table_select),
        .slot(slot), .memory_kind(memory_kind), .byte_offset(byte_offset),
        .cpu_flush(cpu_flush), .last(last), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    always #5 clk = ~clk;

    // shadow page table and registers
    logic [2:0]  cpu_kind [CPU_PAGES];
    logic [21:0] cpu_off [CPU_PAGES];
    logic [2:0]  ppu_kind [PPU_PAGES];
    logic [21:0] ppu_off [PPU_PAGES];
    int unsigned rom_count;
    int unsigned vrom_count;

    page_update_t updates_due[$];
    int errors = 0;
    int cycle_count = 0;
    bit no_idle = 1'b0;
    int hold_requests = 0;

    task automatic report(string what, longint got, longint want);
        errors++;
        if (errors <= 40)
            $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    endtask

    // nametable banks {nt3, nt2, nt1, nt0} of a mirroring mode
    function automatic logic [7:0] mode_nametables(logic [2:0] mode);
        case (mode)
            MIR_VERT: return 8'b01_00_01_00;
            MIR_HORZ: return 8'b01_01_00_00;
            MIR_HIGH: return 8'b01_01_01_01;
            MIR_LOW:  return 8'b00_00_00_00;
            default:  return 8'b11_10_01_00;
        endcase
    endfunction

    function automatic page_update_t rom_write(int unsigned pg, int unsigned bnk);
        page_update_t u;
        int unsigned m;
        logic [21:0] off;
        m = (rom_count == 0) ? 1 : (rom_count > 512 ? 512 : rom_count);
        off = 22'((bnk % m) * 32'h2000);
        u.tsel = 1'b0;
        u.slot = 4'(pg % CPU_PAGES);
        u.kind = KIND_ROM;
        u.offset = off;
        u.flush = (cpu_kind[u.slot[2:0]] != KIND_ROM) || (cpu_off[u.slot[2:0]] != off);
        u.last = 1'b0;
        cpu_kind[u.slot[2:0]] = KIND_ROM;
        cpu_off[u.slot[2:0]] = off;
        return u;
    endfunction

    function automatic page_update_t ppu_write(int unsigned pg, logic [2:0] kind,
                                               int unsigned bnk);
        page_update_t u;
        int unsigned n;
        if (kind == KIND_VROM && vrom_count == 0)
            kind = KIND_CRAM;
        if (kind == KIND_VROM)
            n = vrom_count > 2048 ? 2048 : vrom_count;
        else if (kind == KIND_CRAM)
            n = 32;
        else
            n = 4;
        u.tsel = 1'b1;
        u.slot = 4'(pg % PPU_PAGES);
        u.kind = kind;
        u.offset = 22'((bnk % n) * 32'h400);
        u.flush = 1'b0;
        u.last = 1'b0;
        ppu_kind[u.slot] = kind;
        ppu_off[u.slot] = u.offset;
        return u;
    endfunction

    task automatic reset_table();
        page_update_t u;
        rom_count = 2;
        vrom_count = 0;
        cpu_kind[0] = KIND_RAM;
        cpu_kind[1] = KIND_XRAM;
        cpu_kind[2] = KIND_XRAM;
        cpu_kind[3] = KIND_WRAM;
        for (int i = 0; i < 4; i++) cpu_off[i] = '0;
        for (int i = 0; i < 4; i++) u = rom_write(4 + i, i);
        for (int i = 0; i < 8; i++)
        begin
            ppu_kind[i] = KIND_VROM;
            ppu_off[i] = 22'(i * 32'h400);
        end
        for (int i = 0; i < 8; i++) u = ppu_write(8 + i, KIND_VRAM, i & 1);
    endtask

    // compute the slot updates that one command causes
    task automatic predict_updates(logic [3:0] op, logic [3:0] pg, logic [11:0] bnk,
                                   logic [2:0] mode, logic [7:0] nt);
        page_update_t batch[$];
        page_update_t u;
        int unsigned cnt;
        int unsigned first;
        logic [2:0] kind;
        first = pg;
        case (op)
            OP_ROM8, OP_ROM16, OP_ROM32:
            begin
                cnt = 1 << op;
                if (op == OP_ROM32) first = 4;
                for (int i = 0; i < cnt; i++) batch.push_back(rom_write(first + i, bnk * cnt + i));
            end
            OP_WRAM:
            begin
                u.tsel = 1'b0;
                u.slot = 4'(pg % CPU_PAGES);
                u.kind = KIND_WRAM;
                u.offset = 22'((bnk % 128) * 32'h2000);
                u.flush = 1'b0;
                u.last = 1'b0;
                cpu_kind[u.slot[2:0]] = KIND_WRAM;
                cpu_off[u.slot[2:0]] = u.offset;
                batch.push_back(u);
            end
            OP_VROM1, OP_VROM2, OP_VROM4, OP_VROM8, OP_CRAM1, OP_CRAM2, OP_CRAM4, OP_CRAM8:
            begin
                kind = (op < OP_CRAM1) ? KIND_VROM : KIND_CRAM;
                cnt = 1 << op[1:0];
                if (cnt == 8) first = 0;
                for (int i = 0; i < cnt; i++)
                    batch.push_back(ppu_write(first + i, kind, bnk * cnt + i));
            end
            OP_VRAM: batch.push_back(ppu_write(pg, KIND_VRAM, bnk));
            OP_MIRROR, OP_NT:
            begin
                if (op == OP_NT || mode <= MIR_FOUR)
                begin
                    if (op == OP_MIRROR) nt = mode_nametables(mode);
                    for (int i = 0; i < 8; i++)
                        batch.push_back(ppu_write(8 + i, KIND_VRAM, nt[2 * (i & 3) +: 2]));
                end
            end
            default: ;
        endcase
        if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i]) updates_due.push_back(batch[i]);
    endtask

    // offer one command and hold it until the transfer, then idle for the given gap
    task automatic send_command(logic [3:0] op, logic [3:0] pg, logic [11:0] bnk,
                                logic [2:0] mode, logic [7:0] nt, int gap);
        push <= 1'b1;
        operation <= op;
        page <= pg;
        bank <= bnk;
        mirror_mode <= mode;
        {nt_bank3, nt_bank2, nt_bank1, nt_bank0} <= nt;
        @(posedge clk);
        while (full) @(posedge clk);
        predict_updates(op, pg, bnk, mode, nt);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_random(int gap);
        logic [3:0] op;
        logic [2:0] mode;
        op = 4'($urandom_range(0, 15));
        mode = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
        send_command(op, 4'($urandom), 12'($urandom), mode, 8'($urandom), gap);
    endtask

    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 95) return $urandom_range(1, 4);
        return $urandom_range(20, 80);
    endfunction

    // wait for every expected update, then let the back end settle
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (updates_due.size() > 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_register(logic [2:0] addr, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_sizes(int unsigned rom_n, int unsigned vrom_n);
        drain();
        write_register(REG_ROM_BANKS, 32'(rom_n));
        write_register(REG_VROM_BANKS, 32'(vrom_n));
        rom_count = rom_n & 32'h3FF;
        vrom_count = vrom_n & 32'hFFF;
    endtask

    // every command at the edges of its fields, starting from the power-on table
    task automatic test_directed();
        send_command(OP_ROM8, 4'd0, 12'hFFF, MIR_VERT, 8'h00, 0);
        send_command(OP_ROM8, 4'd4, 12'd0, MIR_VERT, 8'h00, 1);
        send_command(OP_ROM16, 4'd7, 12'd1, MIR_VERT, 8'h00, 0);
        send_command(OP_ROM32, 4'd15, 12'hFFF, MIR_VERT, 8'h00, 2);
        send_command(OP_WRAM, 4'd15, 12'hFFF, MIR_VERT, 8'h00, 0);
        send_command(OP_VROM1, 4'd15, 12'hFFF, MIR_VERT, 8'h00, 0);
        send_command(OP_VROM2, 4'd15, 12'd5, MIR_VERT, 8'h00, 0);
        send_command(OP_VROM4, 4'd14, 12'd3, MIR_VERT, 8'h00, 3);
        send_command(OP_VROM8, 4'd9, 12'hFFF, MIR_VERT, 8'h00, 0);
        send_command(OP_CRAM1, 4'd0, 12'd31, MIR_VERT, 8'h00, 0);
        send_command(OP_CRAM2, 4'd15, 12'hFFF, MIR_VERT, 8'h00, 0);
        send_command(OP_CRAM4, 4'd13, 12'd7, MIR_VERT, 8'h00, 0);
        send_command(OP_CRAM8, 4'd5, 12'd3, MIR_VERT, 8'h00, 0);
        send_command(OP_VRAM, 4'd15, 12'hFFF, MIR_VERT, 8'h00, 0);
        for (int m = 0; m < 8; m++)
            send_command(OP_MIRROR, 4'd0, 12'd0, 3'(m), 8'h00, 0);
        send_command(OP_NT, 4'd0, 12'd0, MIR_VERT, 8'hFF, 0);
        send_command(OP_NT, 4'd0, 12'd0, MIR_VERT, 8'h1B, 0);
        send_command(OP_UNUSED, 4'hF, 12'hFFF, 3'd7, 8'hFF, 0);
        // register extremes, including zero and oversized counts
        set_sizes(0, 2048);
        send_command(OP_ROM32, 4'd0, 12'hABC, MIR_VERT, 8'h00, 0);
        send_command(OP_VROM8, 4'd0, 12'hFFF, MIR_VERT, 8'h00, 0);
        set_sizes(1023, 4095);
        send_command(OP_ROM8, 4'd6, 12'hFFF, MIR_VERT, 8'h00, 0);
        send_command(OP_VROM1, 4'd3, 12'hFFF, MIR_VERT, 8'h00, 0);
    endtask

    // random commands over several register settings
    task automatic test_random_sizes();
        int unsigned rom_set[6] = '{2, 1, 512, 513, 37, 0};
        int unsigned vrom_set[6] = '{0, 2048, 1, 3000, 300, 8};
        for (int p = 0; p < 6; p++)
        begin
            set_sizes(rom_set[p], vrom_set[p]);
            no_idle = (p == 2);
            for (int i = 0; i < 55; i++) send_random(random_gap());
        end
        no_idle = 1'b0;
    endtask

    // hold off the receiver while commands keep coming, so full rises
    task automatic test_backpressure();
        drain();
        hold_requests++;
        for (int i = 0; i < 40; i++) send_random(0);
        drain();
        for (int i = 0; i < 40; i++) send_random(random_gap());
    endtask

    // receiver: check each transfer against the oldest expected update
    int stall_left = 0;
    int long_hold = 0;
    int holds_seen = 0;
    always @(posedge clk)
    begin
        page_update_t want;
        int r;
        cycle_count <= cycle_count + 1;
        if (pop && !empty)
        begin
            if (updates_due.size() == 0)
                report("unexpected update", byte_offset, 0);
            else
            begin
                want = updates_due.pop_front();
                if (table_select !== want.tsel) report("table_select", table_select, want.tsel);
                if (slot !== want.slot) report("slot", slot, want.slot);
                if (memory_kind !== want.kind) report("memory_kind", memory_kind, want.kind);
                if (byte_offset !== want.offset) report("byte_offset", byte_offset, want.offset);
                if (cpu_flush !== want.flush) report("cpu_flush", cpu_flush, want.flush);
                if (last !== want.last) report("last", last, want.last);
            end
        end
        if (holds_seen != hold_requests)
        begin
            holds_seen = hold_requests;
            long_hold = 500;
        end
        if (long_hold > 0)
        begin
            long_hold--;
            pop <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            pop <= 1'b0;
        end
        else
        begin
            pop <= 1'b1;
            r = $urandom_range(0, 99);
            if (!no_idle && r < 20) stall_left = $urandom_range(1, 3);
            else if (!no_idle && r < 22) stall_left = $urandom_range(20, 60);
        end
    end

    // cap the run
    always @(posedge clk)
    begin
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        reset_table();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_sizes();
        test_backpressure();
        drain();
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/bsp_pkg.sv
src/bsp_front.sv
src/bsp_div.sv
src/bsp_back.sv
src/bank_switch_page_table_unit.sv
src/bsp_checker.sv
tb/sv/tb.sv
